// ===== rtl/core/llr_pkg.sv =====
package llr_pkg;

    // Sample and field widths fixed by the stream format.
    localparam int SB        = 24;
    localparam int FS        = 1 << (SB - 1);
    localparam int LOOP_W    = 17;
    localparam int PRE_W     = 24;
    localparam int IDX_W     = 16;
    localparam int MLEN_W    = 17;
    localparam int TOTAL_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 24;
    localparam int IN_W      = 64;
    localparam int OUT_W     = 72;

    // Command queue between the front and the back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREROLL_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERDUB_ENABLE = 2'd2;

    localparam logic [LOOP_W-1:0] LOOP_LENGTH_RESET = 17'd65536;

    typedef enum logic [2:0] {
        OP_SAMPLE = 3'd0,
        OP_START  = 3'd1,
        OP_STOP   = 3'd2,
        OP_UNDO   = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_READ   = 3'd5,
        OP_NONE   = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                    op;
        logic signed [SB-1:0]   left;
        logic signed [SB-1:0]   right;
        logic [IDX_W-1:0]       index;
    } t_cmd;

    typedef struct packed {
        logic signed [SB-1:0]   left;
        logic signed [SB-1:0]   right;
        logic [MLEN_W-1:0]      mixed_length;
        logic [TOTAL_W-1:0]     layer_total;
        logic                   is_recording;
        logic                   is_prerolling;
        t_status                status;
    } t_res;

    typedef struct packed {
        logic [LOOP_W-1:0]      loop_length;
        logic [PRE_W-1:0]       preroll_length;
        logic                   overdub_enable;
    } t_cfg;

endpackage

// ===== rtl/core/llr_front.sv =====
// Request front end: decodes the operation code and hands the request to the queue.
module llr_front import llr_pkg::*; (
    input  logic            i_valid,
    input  logic [IN_W-1:0] i_data,
    input  logic [2:0]      i_user,
    input  logic            i_queue_full,
    output logic            o_ready,
    output logic            o_push,
    output t_cmd            o_cmd
);

    always_comb begin
        // Codes beyond the read operation carry no action.
        o_cmd.op    = (i_user > OP_READ) ? OP_NONE : t_op'(i_user);
        o_cmd.left  = i_data[SB-1:0];
        o_cmd.right = i_data[2*SB-1:SB];
        o_cmd.index = i_data[2*SB+IDX_W-1:2*SB];
    end

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

endmodule

// ===== rtl/core/llr_fifo.sv =====
// Short request queue between the front end and the back end.
module llr_fifo import llr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_fill;

    assign o_full  = (r_fill == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/llr_div.sv =====
// Restoring divider for the normalisation: quotient = num * 2^(SB-1) / den,
// with num never above den, one quotient bit per cycle.
module llr_div import llr_pkg::*; #(
    parameter int MIX_W = 28
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MIX_W-1:0] i_num,
    input  logic [MIX_W-1:0] i_den,
    output logic             o_done,
    output logic [SB-1:0]    o_quot
);

    localparam int CNT_W = $clog2(SB);

    logic [MIX_W:0]   r_rem;
    logic [MIX_W-1:0] r_den;
    logic [SB-1:0]    r_quot;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [MIX_W:0]   w_shift;

    assign w_shift = {r_rem[MIX_W-1:0], 1'b0};
    assign o_done  = r_done;
    assign o_quot  = r_quot;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            if (i_num >= i_den) begin
                r_rem  <= {1'b0, i_num - i_den};
                r_quot <= SB'(1);
            end else begin
                r_rem  <= {1'b0, i_num};
                r_quot <= '0;
            end
            r_cnt <= CNT_W'(SB - 1);
        end else if (r_busy) begin
            if (w_shift >= {1'b0, r_den}) begin
                r_rem  <= w_shift - {1'b0, r_den};
                r_quot <= {r_quot[SB-2:0], 1'b1};
            end else begin
                r_rem  <= w_shift;
                r_quot <= {r_quot[SB-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/llr_back.sv =====
// Execution back end: layer store, layer stack, mix bookkeeping and result register.
module llr_back import llr_pkg::*; #(
    parameter int MAX_LOOP   = 65536,
    parameter int MAX_LAYERS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);

    localparam int SLOTS     = MAX_LAYERS + 1;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(MAX_LAYERS + 1);
    localparam int K_W       = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int LEN_W     = $clog2(MAX_LOOP + 1);
    localparam int ADDR_W    = $clog2(MAX_LOOP);
    localparam int MIX_W     = SB + $clog2(MAX_LAYERS) + 1;
    localparam int MEM_DEPTH = 2 ** (SLOT_W + ADDR_W);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_EXEC    = 11'b00000000010,
        S_POP     = 11'b00000000100,
        S_MAXLEN  = 11'b00000001000,
        S_SUM_RD  = 11'b00000010000,
        S_SUM_ACC = 11'b00000100000,
        S_PEAK    = 11'b00001000000,
        S_SCALE   = 11'b00010000000,
        S_DIV_L   = 11'b00100000000,
        S_DIV_R   = 11'b01000000000,
        S_OUT     = 11'b10000000000
    } t_state;

    t_state                   r_state;
    t_cmd                     r_cmd;
    logic [SLOTS-1:0]         r_used;
    logic [SLOT_W-1:0]        r_stk_slot [MAX_LAYERS];
    logic [LEN_W-1:0]         r_stk_len  [MAX_LAYERS];
    logic [LEN_W-1:0]         r_stk_wr   [MAX_LAYERS];
    logic [CNT_W-1:0]         r_count;
    logic [SLOT_W-1:0]        r_open_slot;
    logic [LEN_W-1:0]         r_open_len;
    logic [LEN_W-1:0]         r_pos;
    logic [PRE_W-1:0]         r_pre_rem;
    logic                     r_rec;
    logic                     r_pre;
    logic                     r_open;
    logic                     r_mix_valid;
    logic [MIX_W-1:0]         r_peak;
    logic [LEN_W-1:0]         r_mix_len;
    logic [CNT_W-1:0]         r_k;
    logic [LEN_W-1:0]         r_i;
    logic                     r_incl;
    logic signed [MIX_W-1:0]  r_sum_l;
    logic signed [MIX_W-1:0]  r_sum_r;
    logic                     r_rd_mode;
    logic [SB-1:0]            r_lo;
    logic [SB-1:0]            r_ro;
    t_status                  r_st;
    logic                     r_div_start;
    logic                     r_out_valid;
    t_res                     r_out;

    logic [2*SB-1:0]          r_mem [MEM_DEPTH];
    logic [2*SB-1:0]          r_rdata;

    logic [K_W-1:0]               w_kidx;
    logic                         w_we;
    logic [SLOT_W+ADDR_W-1:0]     w_waddr;
    logic [SLOT_W+ADDR_W-1:0]     w_raddr;
    logic [LEN_W-1:0]             w_pos_next;
    logic [PRE_W-1:0]             w_pre_next;
    logic                         w_commit;
    logic [SLOT_W-1:0]            w_free;
    logic [LEN_W-1:0]             w_len;
    logic                         w_idx_ok;
    logic signed [MIX_W-1:0]      w_sum_l_nx;
    logic signed [MIX_W-1:0]      w_sum_r_nx;
    logic [MIX_W-1:0]             w_mag_l;
    logic [MIX_W-1:0]             w_mag_r;
    logic [MIX_W-1:0]             w_mag_max;
    logic [MIX_W-1:0]             w_div_num;
    logic                         w_div_done;
    logic [SB-1:0]                w_quot;

    // Signs a magnitude and clips positive full scale to the largest code.
    function automatic logic [SB-1:0] f_sat(input logic neg, input logic [MIX_W-1:0] mag);
        logic [SB-1:0] v;
        v = mag[SB-1:0];
        if (!neg && mag >= MIX_W'(FS)) begin
            return SB'(FS - 1);
        end
        return neg ? (SB'(0) - v) : v;
    endfunction

    assign w_kidx  = r_k[K_W-1:0];
    assign w_raddr = {r_stk_slot[w_kidx], r_i[ADDR_W-1:0]};
    assign w_waddr = {r_open_slot, r_pos[ADDR_W-1:0]};
    assign w_we    = (r_state == S_EXEC) && (r_cmd.op == OP_SAMPLE) && r_rec && !r_pre
                     && r_open && (r_pos < r_open_len);
    assign w_pos_next = w_we ? (r_pos + 1'b1) : r_pos;
    assign w_pre_next = r_pre_rem - PRE_W'(r_pre_rem != '0);
    assign w_commit   = (r_cmd.op == OP_STOP)
                        || ((r_cmd.op == OP_SAMPLE) && r_rec && !r_pre && r_open
                            && (w_pos_next >= r_open_len));
    assign w_idx_ok   = 32'(r_cmd.index) < 32'(r_mix_len);

    always_comb begin
        w_free = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!r_used[s]) begin
                w_free = SLOT_W'(s);
            end
        end
    end

    always_comb begin
        if (i_cfg.loop_length == '0) begin
            w_len = LEN_W'(1);
        end else if (32'(i_cfg.loop_length) > MAX_LOOP) begin
            w_len = LEN_W'(MAX_LOOP);
        end else begin
            w_len = LEN_W'(i_cfg.loop_length);
        end
    end

    always_comb begin
        w_sum_l_nx = r_sum_l;
        w_sum_r_nx = r_sum_r;
        if (r_incl) begin
            w_sum_l_nx = r_sum_l + {{(MIX_W-SB){r_rdata[2*SB-1]}}, r_rdata[2*SB-1:SB]};
            w_sum_r_nx = r_sum_r + {{(MIX_W-SB){r_rdata[SB-1]}}, r_rdata[SB-1:0]};
        end
    end

    assign w_mag_l   = r_sum_l[MIX_W-1] ? MIX_W'(-r_sum_l) : MIX_W'(r_sum_l);
    assign w_mag_r   = r_sum_r[MIX_W-1] ? MIX_W'(-r_sum_r) : MIX_W'(r_sum_r);
    assign w_mag_max = (w_mag_l > w_mag_r) ? w_mag_l : w_mag_r;
    assign w_div_num = (r_state == S_DIV_R) ? w_mag_r : w_mag_l;

    llr_div #(
        .MIX_W(MIX_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (w_div_num),
        .i_den   (r_peak),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Layer sample store: one write port for recording, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= {r_cmd.left, r_cmd.right};
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid && !r_out_valid;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_count     <= '0;
            r_open_slot <= '0;
            r_pos       <= '0;
            r_pre_rem   <= '0;
            r_rec       <= 1'b0;
            r_pre       <= 1'b0;
            r_open      <= 1'b0;
            r_mix_valid <= 1'b0;
            r_peak      <= '0;
            r_mix_len   <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_cmd   <= i_cmd;
                        r_lo    <= '0;
                        r_ro    <= '0;
                        r_st    <= ST_OK;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_OUT;
                    unique case (r_cmd.op)
                        OP_SAMPLE: begin
                            if (r_rec && r_pre) begin
                                r_pre_rem <= w_pre_next;
                                if (w_pre_next == '0) begin
                                    r_pre <= 1'b0;
                                end
                            end
                            if (w_we) begin
                                r_pos <= w_pos_next;
                            end
                        end
                        OP_START: begin
                            if (!i_cfg.overdub_enable) begin
                                r_used      <= '0;
                                r_count     <= '0;
                                r_open_slot <= '0;
                            end else begin
                                r_open_slot <= w_free;
                            end
                            r_open_len  <= w_len;
                            r_open      <= 1'b1;
                            r_pos       <= '0;
                            r_pre_rem   <= i_cfg.preroll_length;
                            r_pre       <= (i_cfg.preroll_length != '0);
                            r_rec       <= 1'b1;
                            r_mix_valid <= 1'b0;
                            r_peak      <= '0;
                            r_mix_len   <= w_len;
                        end
                        OP_UNDO: begin
                            if (r_count == '0) begin
                                r_st <= ST_EMPTY;
                            end else begin
                                r_count <= r_count - 1'b1;
                                r_k     <= r_count - 1'b1;
                                r_state <= S_POP;
                            end
                        end
                        OP_CLEAR: begin
                            r_rec       <= 1'b0;
                            r_pre       <= 1'b0;
                            r_open      <= 1'b0;
                            r_used      <= '0;
                            r_count     <= '0;
                            r_pos       <= '0;
                            r_pre_rem   <= '0;
                            r_mix_valid <= 1'b0;
                            r_peak      <= '0;
                            r_mix_len   <= '0;
                        end
                        OP_READ: begin
                            if (r_mix_valid && w_idx_ok) begin
                                r_i       <= LEN_W'(r_cmd.index);
                                r_k       <= '0;
                                r_sum_l   <= '0;
                                r_sum_r   <= '0;
                                r_rd_mode <= 1'b1;
                                r_state   <= S_SUM_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (w_commit) begin
                        r_rec <= 1'b0;
                        r_pre <= 1'b0;
                        if (r_open) begin
                            r_open <= 1'b0;
                            if (32'(r_count) >= MAX_LAYERS) begin
                                r_st <= ST_FULL;
                            end else begin
                                r_stk_slot[r_count[K_W-1:0]] <= r_open_slot;
                                r_stk_len[r_count[K_W-1:0]]  <= r_open_len;
                                r_stk_wr[r_count[K_W-1:0]]   <= w_pos_next;
                                r_used[r_open_slot]          <= 1'b1;
                                r_count   <= r_count + 1'b1;
                                r_k       <= '0;
                                r_mix_len <= '0;
                                r_state   <= S_MAXLEN;
                            end
                        end
                    end
                end
                S_POP: begin
                    r_used[r_stk_slot[w_kidx]] <= 1'b0;
                    if (r_count == '0) begin
                        // An empty stack leaves a silent mix of unchanged length.
                        r_mix_valid <= 1'b0;
                        r_peak      <= '0;
                        r_state     <= S_OUT;
                    end else begin
                        r_k       <= '0;
                        r_mix_len <= '0;
                        r_state   <= S_MAXLEN;
                    end
                end
                S_MAXLEN: begin
                    if (r_k < r_count) begin
                        if (r_stk_len[w_kidx] > r_mix_len) begin
                            r_mix_len <= r_stk_len[w_kidx];
                        end
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_mix_valid <= 1'b1;
                        r_peak      <= '0;
                        r_i         <= '0;
                        r_k         <= '0;
                        r_sum_l     <= '0;
                        r_sum_r     <= '0;
                        r_rd_mode   <= 1'b0;
                        r_state     <= S_SUM_RD;
                    end
                end
                S_SUM_RD: begin
                    r_incl  <= (r_i < r_stk_wr[w_kidx]);
                    r_state <= S_SUM_ACC;
                end
                S_SUM_ACC: begin
                    r_sum_l <= w_sum_l_nx;
                    r_sum_r <= w_sum_r_nx;
                    if (32'(r_k) + 1 < 32'(r_count)) begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_SUM_RD;
                    end else if (r_rd_mode) begin
                        r_state <= S_SCALE;
                    end else begin
                        r_state <= S_PEAK;
                    end
                end
                S_PEAK: begin
                    if (w_mag_max > r_peak) begin
                        r_peak <= w_mag_max;
                    end
                    if (32'(r_i) + 1 < 32'(r_mix_len)) begin
                        r_i     <= r_i + 1'b1;
                        r_k     <= '0;
                        r_sum_l <= '0;
                        r_sum_r <= '0;
                        r_state <= S_SUM_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_SCALE: begin
                    if (r_peak > MIX_W'(FS)) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV_L;
                    end else begin
                        r_lo    <= f_sat(r_sum_l[MIX_W-1], w_mag_l);
                        r_ro    <= f_sat(r_sum_r[MIX_W-1], w_mag_r);
                        r_state <= S_OUT;
                    end
                end
                S_DIV_L: begin
                    if (w_div_done) begin
                        r_lo        <= f_sat(r_sum_l[MIX_W-1], MIX_W'(w_quot));
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV_R;
                    end
                end
                S_DIV_R: begin
                    if (w_div_done) begin
                        r_ro    <= f_sat(r_sum_r[MIX_W-1], MIX_W'(w_quot));
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_out.left          <= r_lo;
                    r_out.right         <= r_ro;
                    r_out.mixed_length  <= MLEN_W'(r_mix_len);
                    r_out.layer_total   <= TOTAL_W'(r_count);
                    r_out.is_recording  <= r_rec;
                    r_out.is_prerolling <= r_pre;
                    r_out.status        <= r_st;
                    r_out_valid         <= 1'b1;
                    r_state             <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/layered_loop_recorder.sv =====
// Layered stereo loop recorder. Each request on the slave stream carries an
// operation (sample, start, stop, undo, clear or read) and answers with exactly
// one response on the master stream, giving the mixed pair for a read and the
// recorder state in every case. Requests are decoded in a front end and queued
// (four entries deep), so the slave side keeps accepting while the back end
// works and while a response waits in the output register, until the queue is
// full. The back end takes one request at a time. Sample, start, stop, clear
// and unused codes pass through the dispatch, execute and response register
// steps, with a mix rebuild added when they commit a layer. A read fetches
// every committed layer in turn from the single read port of the layer store,
// and when the mix is louder than full scale both channels pass through the
// one-bit-per-cycle divider. A commit or undo rebuilds the mix: it first finds
// the longest layer, then sums every layer at each sample position to find
// the peak. The mixed sums are not stored; a read recomputes its position
// from the layer store. Layer storage is a memory of (layers+1) slots of
// MAX_LOOP stereo words, which needs no clearing after reset. Configuration
// writes are taken at any time but must only be made while the recorder is
// idle.
module layered_loop_recorder import llr_pkg::*; #(
    parameter int MAX_LOOP   = 65536,
    parameter int MAX_LAYERS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // left_in [23:0], right_in [47:24], read_index [63:48]
    input  logic [IN_W-1:0]      s_axis_tdata,
    // op [2:0]
    input  logic [2:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // left_out [23:0], right_out [47:24], mixed_length [64:48],
    // layer_total [68:65], is_recording [69], is_prerolling [70], zero [71]
    output logic [OUT_W-1:0]     m_axis_tdata,
    // status [1:0]
    output logic [1:0]           m_axis_tuser,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg r_cfg;
    t_cmd w_front_cmd;
    t_cmd w_queue_cmd;
    t_res w_res;
    logic w_push;
    logic w_full;
    logic w_queue_valid;
    logic w_pop;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.loop_length    <= LOOP_LENGTH_RESET;
            r_cfg.preroll_length <= '0;
            r_cfg.overdub_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LOOP_LENGTH:    r_cfg.loop_length    <= i_cfg_data[LOOP_W-1:0];
                CFG_PREROLL_LENGTH: r_cfg.preroll_length <= i_cfg_data[PRE_W-1:0];
                CFG_OVERDUB_ENABLE: r_cfg.overdub_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    llr_front u_front (
        .i_valid      (s_axis_tvalid),
        .i_data       (s_axis_tdata),
        .i_user       (s_axis_tuser),
        .i_queue_full (w_full),
        .o_ready      (s_axis_tready),
        .o_push       (w_push),
        .o_cmd        (w_front_cmd)
    );

    llr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_queue_valid),
        .o_cmd   (w_queue_cmd)
    );

    llr_back #(
        .MAX_LOOP   (MAX_LOOP),
        .MAX_LAYERS (MAX_LAYERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_queue_valid),
        .i_cmd       (w_queue_cmd),
        .o_cmd_pop   (w_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    assign m_axis_tdata = {1'b0, w_res.is_prerolling, w_res.is_recording, w_res.layer_total,
                           w_res.mixed_length, w_res.right, w_res.left};
    assign m_axis_tuser = w_res.status;

endmodule
